>>> rtl/core/triangle_unit_normal_core_defines.svh
// Assertion macros shared by the triangle normal checker
`ifndef TRIANGLE_UNIT_NORMAL_CORE_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_CORE_DEFINES_SVH

// Same-cycle implication, ignored during reset
`define TUN_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("triangle normal check failed");

// Next-cycle implication, ignored during reset
`define TUN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("triangle normal check failed");

// Next-cycle implication that also holds across reset
`define TUN_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("triangle normal check failed");

`endif

>>> rtl/core/tun_pkg.sv
// Shared constants for the triangle unit normal core
`timescale 1ns / 1ps
`default_nettype none
package tun_pkg;
  localparam int unsigned NUM_COMP  = 3;
  localparam int unsigned IN_FIELDS = 9;
endpackage
`default_nettype wire

>>> rtl/core/triangle_unit_normal_core.sv
// Triangle unit face normal: edges, cross product, square root and scaled divide
//
// Input stream (s_axis): one triangle per item, nine signed Q8.8 coordinates
// p0..p2 packed in tdata. Output stream (m_axis): the unit normal in signed
// Q1.14 in tdata and the degenerate flag in tuser. cfg_we/cfg_wdata write the
// degenerate limit; a face whose squared cross length is at or below it gives
// the default normal (0,0,1) with the flag raised.
// Throughput: one item per cycle unless the receiver stalls a result. The
// square root takes one result bit per stage and each divider one quotient
// bit per stage, which sets the depth.
// Reset clears all valid bits and sets the limit to zero.
// When the receiver stalls a valid result, the whole pipeline holds and
// s_axis_tready drops in the same cycle; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module triangle_unit_normal_core #(
  parameter int COORD_WIDTH      = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [31:0]         cfg_wdata,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z
  input  wire logic [((tun_pkg::IN_FIELDS*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // normal_x, normal_y, normal_z
  output logic [((tun_pkg::NUM_COMP*(NORMAL_FRAC_BITS+2)+7)/8)*8-1:0] m_axis_tdata,
  // degenerate
  output logic                     m_axis_tuser
);
  localparam int NC    = tun_pkg::NUM_COMP;
  localparam int CW    = COORD_WIDTH;
  localparam int EW    = CW + 1;
  localparam int PW    = 2 * EW;
  localparam int CRW   = PW + 1;
  localparam int MW    = CRW - 1;
  localparam int H     = (MW + 1) / 2;
  localparam int HW    = MW - H;
  localparam int SW    = 2 * MW + 2;
  localparam int RW    = MW + 1;
  localparam int RMW   = RW + 3;
  localparam int QW    = NORMAL_FRAC_BITS + 1;
  localparam int OW    = NORMAL_FRAC_BITS + 2;
  localparam int OUT_W = ((NC * OW + 7) / 8) * 8;
  localparam logic [OW-1:0] UNIT = OW'(1) << NORMAL_FRAC_BITS;

  logic [31:0] limit;
  logic        adv;
  logic        out_v;

  // Advance the whole pipeline unless a result waits
  assign adv           = !out_v || m_axis_tready;
  assign s_axis_tready = adv;

  // Hold the degenerate limit
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= '0;
    end else if (cfg_we) begin
      limit <= cfg_wdata;
    end
  end

  // Stage 1: edge vectors
  logic signed [CW-1:0] px [tun_pkg::IN_FIELDS];
  logic signed [EW-1:0] e1 [6];
  logic                 v1;
  always_comb begin
    for (int i = 0; i < int'(tun_pkg::IN_FIELDS); i++) begin
      px[i] = s_axis_tdata[i*CW +: CW];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= s_axis_tvalid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        e1[i]     <= $signed({px[3+i][CW-1], px[3+i]}) - $signed({px[i][CW-1], px[i]});
        e1[3 + i] <= $signed({px[6+i][CW-1], px[6+i]}) - $signed({px[i][CW-1], px[i]});
      end
    end
  end

  // Stage 2: cross product terms
  logic signed [PW-1:0] pr [6];
  logic                 v2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      pr[0] <= e1[1] * e1[5];
      pr[1] <= e1[2] * e1[4];
      pr[2] <= e1[2] * e1[3];
      pr[3] <= e1[0] * e1[5];
      pr[4] <= e1[0] * e1[4];
      pr[5] <= e1[1] * e1[3];
    end
  end

  // Stage 3: cross product components
  logic signed [CRW-1:0] cr [NC];
  logic                  v3;
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NC; i++) begin
        cr[i] <= $signed({pr[2*i][PW-1], pr[2*i]}) - $signed({pr[2*i+1][PW-1], pr[2*i+1]});
      end
    end
  end

  // Stage 4: magnitudes and signs
  logic [NC-1:0][MW-1:0] mg4;
  logic [NC-1:0]         ng4;
  logic                  v4;
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NC; i++) begin
        ng4[i] <= cr[i][CRW-1];
        mg4[i] <= cr[i][CRW-1] ? MW'(-cr[i]) : MW'(cr[i]);
      end
    end
  end

  // Stage 5: partial products of the squares
  logic [NC-1:0][2*HW-1:0] hh5;
  logic [NC-1:0][MW-1:0]   hl5;
  logic [NC-1:0][2*H-1:0]  ll5;
  logic [NC-1:0][MW-1:0]   mg5;
  logic [NC-1:0]           ng5;
  logic                    v5;
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NC; i++) begin
        hh5[i] <= mg4[i][MW-1:H] * mg4[i][MW-1:H];
        hl5[i] <= mg4[i][MW-1:H] * mg4[i][H-1:0];
        ll5[i] <= mg4[i][H-1:0] * mg4[i][H-1:0];
      end
      mg5 <= mg4;
      ng5 <= ng4;
    end
  end

  // Stage 6: squares
  logic [NC-1:0][2*MW-1:0] sq6;
  logic [NC-1:0][MW-1:0]   mg6;
  logic [NC-1:0]           ng6;
  logic                    v6;
  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= v5;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NC; i++) begin
        sq6[i] <= ((2*MW)'(hh5[i]) << (2*H)) + ((2*MW)'(hl5[i]) << (H+1))
                  + (2*MW)'(ll5[i]);
      end
      mg6 <= mg5;
      ng6 <= ng5;
    end
  end

  // Stage 7: squared length and limit test
  logic [SW-1:0]         s7;
  logic                  dg7;
  logic [NC-1:0][MW-1:0] mg7;
  logic [NC-1:0]         ng7;
  logic                  v7;
  logic [SW-1:0]         ssum;
  assign ssum = SW'(sq6[0]) + SW'(sq6[1]) + SW'(sq6[2]);
  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= v6;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s7  <= ssum;
      dg7 <= ssum <= SW'(limit);
      mg7 <= mg6;
      ng7 <= ng6;
    end
  end

  // Square root: one root bit per stage
  logic                  sq_v    [1:RW];
  logic                  sq_dg   [1:RW];
  logic [NC-1:0]         sq_ng   [1:RW];
  logic [NC-1:0][MW-1:0] sq_mg   [1:RW];
  logic [RMW-1:0]        sq_rem  [1:RW];
  logic [RW-1:0]         sq_root [1:RW];
  logic [SW-1:0]         sq_s    [1:RW];

  for (genvar k = 1; k <= RW; k++) begin : g_sqrt
    logic                  vi, dgi;
    logic [NC-1:0]         ngi;
    logic [NC-1:0][MW-1:0] mgi;
    logic [RMW-1:0]        remi, ri, tt;
    logic [RW-1:0]         rooti;
    logic [SW-1:0]         si;
    logic                  ge;
    if (k == 1) begin : g_src
      assign vi    = v7;
      assign dgi   = dg7;
      assign ngi   = ng7;
      assign mgi   = mg7;
      assign remi  = '0;
      assign rooti = '0;
      assign si    = s7;
    end else begin : g_src
      assign vi    = sq_v[k-1];
      assign dgi   = sq_dg[k-1];
      assign ngi   = sq_ng[k-1];
      assign mgi   = sq_mg[k-1];
      assign remi  = sq_rem[k-1];
      assign rooti = sq_root[k-1];
      assign si    = sq_s[k-1];
    end
    assign ri = {remi[RMW-3:0], si[SW-1 -: 2]};
    assign tt = {1'b0, rooti, 2'b01};
    assign ge = ri >= tt;
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k] <= 1'b0;
      end else if (adv) begin
        sq_v[k] <= vi;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_dg[k]   <= dgi;
        sq_ng[k]   <= ngi;
        sq_mg[k]   <= mgi;
        sq_rem[k]  <= ge ? ri - tt : ri;
        sq_root[k] <= {rooti[RW-2:0], ge};
        sq_s[k]    <= si << 2;
      end
    end
  end

  // Scaled division: one quotient bit per stage for each component
  logic                  dv_v   [1:QW];
  logic                  dv_dg  [1:QW];
  logic [NC-1:0]         dv_ng  [1:QW];
  logic [RW-1:0]         dv_r   [1:QW];
  logic [NC-1:0][RW:0]   dv_rem [1:QW];
  logic [NC-1:0][QW-1:0] dv_q   [1:QW];

  for (genvar k = 1; k <= QW; k++) begin : g_div
    logic                  vi, dgi;
    logic [NC-1:0]         ngi;
    logic [RW-1:0]         rdi;
    logic [NC-1:0][RW:0]   remi, remo;
    logic [NC-1:0][QW-1:0] qi, qo;
    if (k == 1) begin : g_src
      assign vi  = sq_v[RW];
      assign dgi = sq_dg[RW];
      assign ngi = sq_ng[RW];
      assign rdi = sq_root[RW];
      for (genvar c = 0; c < NC; c++) begin : g_c
        assign remi[c] = (RW+1)'(sq_mg[RW][c]);
      end
      assign qi = '0;
    end else begin : g_src
      assign vi   = dv_v[k-1];
      assign dgi  = dv_dg[k-1];
      assign ngi  = dv_ng[k-1];
      assign rdi  = dv_r[k-1];
      assign remi = dv_rem[k-1];
      assign qi   = dv_q[k-1];
    end
    always_comb begin
      logic [RW:0] sub;
      logic        ge;
      for (int c = 0; c < NC; c++) begin
        ge      = remi[c] >= {1'b0, rdi};
        sub     = ge ? remi[c] - {1'b0, rdi} : remi[c];
        remo[c] = {sub[RW-1:0], 1'b0};
        qo[c]   = {qi[c][QW-2:0], ge};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k] <= 1'b0;
      end else if (adv) begin
        dv_v[k] <= vi;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_dg[k]  <= dgi;
        dv_ng[k]  <= ngi;
        dv_r[k]   <= rdi;
        dv_rem[k] <= remo;
        dv_q[k]   <= qo;
      end
    end
  end

  // Output register: apply signs or the default normal
  logic [NC-1:0][OW-1:0] nrm;
  logic                  dg_out;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv) begin
      out_v <= dv_v[QW];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      dg_out <= dv_dg[QW];
      for (int c = 0; c < NC; c++) begin
        if (dv_dg[QW]) begin
          nrm[c] <= (c == NC - 1) ? UNIT : '0;
        end else if (dv_ng[QW][c]) begin
          nrm[c] <= OW'(0) - {1'b0, dv_q[QW][c]};
        end else begin
          nrm[c] <= {1'b0, dv_q[QW][c]};
        end
      end
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = OUT_W'(nrm);
  assign m_axis_tuser  = dg_out;
endmodule
`default_nettype wire

>>> rtl/core/tun_checker.sv
// Port-level checks for the triangle unit normal core, with its bind
`timescale 1ns / 1ps
`default_nettype none
`include "triangle_unit_normal_core_defines.svh"
module tun_checker #(
  parameter int COORD_WIDTH      = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic [((tun_pkg::NUM_COMP*(NORMAL_FRAC_BITS+2)+7)/8)*8-1:0] m_axis_tdata,
  input wire logic m_axis_tuser
);
  localparam int OW = NORMAL_FRAC_BITS + 2;
  localparam logic [OW-1:0] UNIT = OW'(1) << NORMAL_FRAC_BITS;
  localparam int CWC = COORD_WIDTH;

  logic [OW-1:0] nx, ny, nz;
  logic          stalled;
  assign nx      = m_axis_tdata[OW-1:0];
  assign ny      = m_axis_tdata[2*OW-1:OW];
  assign nz      = m_axis_tdata[3*OW-1:2*OW];
  assign stalled = m_axis_tvalid && !m_axis_tready && (CWC > 0);

  // A degenerate face carries exactly the default normal
  `TUN_ASSERT_NOW(a_default_normal, m_axis_tvalid && m_axis_tuser, nx == '0 && ny == '0 && nz == UNIT)
  // A stalled result blocks new input
  `TUN_ASSERT_NOW(a_stall_blocks_input, stalled, !s_axis_tready)
  // A stalled result stays put
  `TUN_ASSERT_NEXT(a_hold_result, stalled, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  // Reset empties the pipeline
  `TUN_ASSERT_ALWAYS(a_reset_empty, rst, !m_axis_tvalid)
endmodule

bind triangle_unit_normal_core tun_checker #(
  .COORD_WIDTH(COORD_WIDTH),
  .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
) u_tun_checker (
  .clk(clk),
  .rst(rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata),
  .m_axis_tuser(m_axis_tuser)
);
`default_nettype wire

>>> dv/triangle_unit_normal_core_tb.sv
// Testbench for the triangle unit normal core: directed faces, then random streams
`timescale 1ns / 1ps
`default_nettype none
module triangle_unit_normal_core_tb;

  localparam int CW = 16;
  localparam int FB = 14;
  localparam int IN_W = ((tun_pkg::IN_FIELDS*CW+7)/8)*8;
  localparam int OUT_W = ((tun_pkg::NUM_COMP*(FB+2)+7)/8)*8;
  localparam int PIPE_LAT = 58;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [FB+1:0] nz;
    logic [FB+1:0] ny;
    logic [FB+1:0] nx;
    logic          degen;
  } normal_t;

  logic clk, rst;
  logic cfg_we;
  logic [31:0] cfg_wdata;
  logic s_axis_tvalid, s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic m_axis_tuser;

  triangle_unit_normal_core DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  // Model copy of the limit register
  logic [31:0] limit_q;
  normal_t normal_queue[$];
  int errors, faces_sent, normals_seen, degen_seen, cycles;
  bit idle_en;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Floor square root of a 128-bit value
  function automatic logic [63:0] isqrt128(logic [127:0] s);
    logic [63:0] r, t;
    r = '0;
    for (int b = 62; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= s) r = t;
    end
    return r;
  endfunction

  // Component c * 2^FB / r, truncated toward zero
  function automatic logic [FB+1:0] scale_comp(logic signed [63:0] c, logic [63:0] r);
    logic [127:0] m, q;
    m = (c < 0) ? -c : c;
    q = (m << FB) / r;
    if (c < 0) q = -q;
    return q[FB+1:0];
  endfunction

  // Expected normal of one face
  function automatic normal_t face_normal(logic [IN_W-1:0] d);
    logic signed [63:0] p[9];
    logic signed [63:0] e1x, e1y, e1z, e2x, e2y, e2z, cx, cy, cz;
    logic [127:0] s, ax, ay, az;
    logic [63:0] r;
    normal_t n;
    for (int i = 0; i < 9; i++) p[i] = $signed(d[i*CW +: CW]);
    e1x = p[3] - p[0]; e1y = p[4] - p[1]; e1z = p[5] - p[2];
    e2x = p[6] - p[0]; e2y = p[7] - p[1]; e2z = p[8] - p[2];
    cx = e1y*e2z - e1z*e2y;
    cy = e1z*e2x - e1x*e2z;
    cz = e1x*e2y - e1y*e2x;
    ax = (cx < 0) ? -cx : cx;
    ay = (cy < 0) ? -cy : cy;
    az = (cz < 0) ? -cz : cz;
    s = ax*ax + ay*ay + az*az;
    if (s <= {96'd0, limit_q}) begin
      n.nx = '0; n.ny = '0; n.nz = (FB+2)'(1 << FB); n.degen = 1'b1;
    end else begin
      r = isqrt128(s);
      n.nx = scale_comp(cx, r); n.ny = scale_comp(cy, r); n.nz = scale_comp(cz, r);
      n.degen = 1'b0;
    end
    return n;
  endfunction

  // Send one face, with random gaps before it
  task automatic send_face(logic [IN_W-1:0] d);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    normal_queue.insert(normal_queue.size(), face_normal(d));
    faces_sent++;
  endtask

  // Drop the input valid and wait until every expected normal has come
  task automatic drain_faces();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (normal_queue.size() != 0) @(posedge clk);
  endtask

  function automatic logic [IN_W-1:0] pack_face(int v[9]);
    logic [IN_W-1:0] d;
    d = '0;
    for (int i = 0; i < 9; i++) d[i*CW +: CW] = v[i][CW-1:0];
    return d;
  endfunction

  // Wait for drain and pipeline flush, then write the limit
  task automatic set_limit(logic [31:0] v);
    drain_faces();
    repeat (PIPE_LAT + 4) @(posedge clk);
    cfg_we <= 1'b1; cfg_wdata <= v; limit_q = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [IN_W-1:0] rand_face(int span);
    int v[9];
    for (int i = 0; i < 9; i++)
      v[i] = (span >= 32768) ? int'($urandom_range(0, 65535)) - 32768
                             : int'($urandom_range(0, 2*span)) - span;
    return pack_face(v);
  endfunction

  // Check the extremes of the coordinate fields and degenerate shapes
  task automatic test_directed();
    int v[9];
    v = '{0, 0, 0, 256, 0, 0, 0, 256, 0};                 send_face(pack_face(v));
    v = '{0, 0, 0, 0, 256, 0, 256, 0, 0};                 send_face(pack_face(v));
    v = '{0, 0, 0, 0, 0, 256, 256, 0, 0};                 send_face(pack_face(v));
    v = '{5, 5, 5, 5, 5, 5, 5, 5, 5};                     send_face(pack_face(v));
    v = '{0, 0, 0, 100, 100, 100, 200, 200, 200};         send_face(pack_face(v));
    v = '{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768};
    send_face(pack_face(v));
    v = '{32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767};
    send_face(pack_face(v));
    v = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, -32768, 32767};
    send_face(pack_face(v));
    v = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};            send_face(pack_face(v));
    v = '{0, 0, 0, 1, 0, 0, 0, 1, 0};                     send_face(pack_face(v));
    v = '{0, 0, 0, 1, 1, 0, 0, 1, 1};                     send_face(pack_face(v));
    v = '{0, 0, 0, 3, -7, 2, -5, 1, 9};                   send_face(pack_face(v));
  endtask

  // Near the degenerate threshold: tiny faces with a small limit
  task automatic test_small_limit();
    set_limit(32'd3);
    for (int i = 0; i < 40; i++) send_face(rand_face(2));
    set_limit(32'd0);
    for (int i = 0; i < 40; i++) send_face(rand_face(2));
  endtask

  // Extreme limits: all-ones makes most faces degenerate
  task automatic test_limit_extremes();
    set_limit(32'hFFFF_FFFF);
    for (int i = 0; i < 40; i++) send_face(rand_face($urandom_range(0, 1) ? 64 : 32768));
    set_limit(32'h0001_0000);
    for (int i = 0; i < 40; i++) send_face(rand_face(40));
  endtask

  // Random faces over the full range and small spans with idling
  task automatic test_random();
    set_limit(32'd0);
    for (int i = 0; i < 300; i++) begin
      send_face(rand_face($urandom_range(0, 2) == 0 ? 32768 : (1 << $urandom_range(1, 14))));
      if (i == 150) drain_faces();
    end
  endtask

  // Back-to-back faces with no idling on either side
  task automatic test_full_rate();
    idle_en = 1'b0;
    for (int i = 0; i < 80; i++) send_face(rand_face(32768));
  endtask

  // Receiver stalls in bursts
  initial begin
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (idle_en && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare each accepted normal with the oldest expectation
  always @(posedge clk) begin
    normal_t exp_n, got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[3*(FB+2)-1:0], m_axis_tuser};
      if (normal_queue.size() == 0) begin
        $display("%0t: unexpected normal %h", $time, got);
        errors++;
      end else begin
        exp_n = normal_queue.pop_front();
        normals_seen++;
        if (got.degen) degen_seen++;
        if (got.nx !== exp_n.nx) begin
          $display("%0t: normal_x expected %h actual %h", $time, exp_n.nx, got.nx); errors++;
        end
        if (got.ny !== exp_n.ny) begin
          $display("%0t: normal_y expected %h actual %h", $time, exp_n.ny, got.ny); errors++;
        end
        if (got.nz !== exp_n.nz) begin
          $display("%0t: normal_z expected %h actual %h", $time, exp_n.nz, got.nz); errors++;
        end
        if (got.degen !== exp_n.degen) begin
          $display("%0t: degenerate expected %b actual %b", $time, exp_n.degen, got.degen);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst = 1'b1; cfg_we = 1'b0; cfg_wdata = '0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    limit_q = '0; idle_en = 1'b1;
    errors = 0; faces_sent = 0; normals_seen = 0; degen_seen = 0; cycles = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_small_limit();
    test_limit_extremes();
    test_random();
    test_full_rate();
    drain_faces();
    repeat (PIPE_LAT + 10) @(posedge clk);
    $display("Sent %0d faces, checked %0d normals (%0d degenerate)",
             faces_sent, normals_seen, degen_seen);
    $display("Limits covered: zero, small, mid and all ones; idle bursts and full rate");
    if (errors == 0 && normal_queue.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
+incdir+rtl/core
rtl/core/tun_pkg.sv
rtl/core/triangle_unit_normal_core.sv
rtl/core/tun_checker.sv
dv/triangle_unit_normal_core_tb.sv
